FILE: sv/alis_pkg.sv
package alis_pkg;

  localparam int unsigned MaxStreams  = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned StreamCntW  = 5;
  localparam int unsigned CountW      = 28;
  localparam int unsigned SumW        = 64;
  localparam int unsigned WordW       = 32;
  localparam int unsigned OffsetW     = 33;
  localparam int unsigned SnW         = 13;
  localparam int unsigned ReqIdxW     = 7;
  localparam int unsigned AsciiZero   = 48;
  localparam int unsigned DigitBase   = 10;
  localparam int unsigned AbsOffsetAdd = 8;
  localparam int unsigned ModeTestAdd = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMoviePos    = 2'd0,
    CfgStreamCount = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic              start_of_table;
    logic [7:0]        id_first_char;
    logic [7:0]        id_second_char;
    logic [WordW-1:0]  entry_flags;
    logic [WordW-1:0]  entry_offset;
    logic [WordW-1:0]  entry_length;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         stream_number;
    logic [CountW-1:0]  position_in_stream;
    logic [OffsetW-1:0] file_offset;
    logic [WordW-1:0]   chunk_length;
    logic [WordW-1:0]   chunk_flags;
    logic [SumW-1:0]    length_before;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic               hit;
    logic [ReqIdxW-1:0] idx;
  } tbl_req_t;

endpackage

FILE: sv/alis_entry_decode.sv
module alis_entry_decode #(
  parameter int unsigned MAX_STREAMS = alis_pkg::MaxStreams
) (
  input  alis_pkg::in_item_t                     item_i,
  input  logic [alis_pkg::WordW-1:0]             movie_pos_i,
  input  logic [alis_pkg::StreamCntW-1:0]        stream_count_i,
  input  logic                                   abs_mode_q_i,
  output alis_pkg::tbl_req_t                     req_o,
  output logic                                   abs_mode_o,
  output logic [alis_pkg::OffsetW-1:0]           file_offset_o
);

  localparam int unsigned SnW = alis_pkg::SnW;
  localparam logic [SnW-1:0] SnBias =
    SnW'(alis_pkg::AsciiZero * (alis_pkg::DigitBase + 1));

  logic [SnW-1:0]               sn_raw;
  logic [SnW-1:0]               sn;
  logic [alis_pkg::WordW-1:0]   mode_test;
  logic                         sn_ok;

  always_comb begin
    sn_raw = SnW'(item_i.id_first_char) * SnW'(alis_pkg::DigitBase)
           + SnW'(item_i.id_second_char);
    sn     = sn_raw - SnBias;
    sn_ok  = !sn[SnW-1]
          && (sn < SnW'(stream_count_i))
          && (sn < SnW'(MAX_STREAMS));

    mode_test = item_i.entry_offset + alis_pkg::WordW'(alis_pkg::ModeTestAdd);
    abs_mode_o = item_i.start_of_table ? (mode_test == movie_pos_i) : abs_mode_q_i;

    if (abs_mode_o) begin
      file_offset_o = {1'b0, item_i.entry_offset}
                    + alis_pkg::OffsetW'(alis_pkg::AbsOffsetAdd);
    end else begin
      file_offset_o = {1'b0, item_i.entry_offset} + {1'b0, movie_pos_i};
    end

    req_o.start = item_i.start_of_table;
    req_o.hit   = sn_ok;
    req_o.idx   = sn[alis_pkg::ReqIdxW-1:0];
  end

endmodule

FILE: sv/alis_stream_table.sv
module alis_stream_table #(
  parameter int unsigned MAX_STREAMS = alis_pkg::MaxStreams
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  alis_pkg::tbl_req_t              req_i,
  input  logic                            step_i,
  input  logic [alis_pkg::WordW-1:0]      length_i,
  output logic [alis_pkg::CountW-1:0]     count_o,
  output logic [alis_pkg::SumW-1:0]       sum_o
);

  localparam int unsigned IdxW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

  logic [MAX_STREAMS-1:0]         valid_q;
  logic [MAX_STREAMS-1:0]         valid_d;
  logic [alis_pkg::CountW-1:0]    cnt_q [MAX_STREAMS];
  logic [alis_pkg::SumW-1:0]      sum_q [MAX_STREAMS];
  logic [IdxW-1:0]                idx;
  logic                           rd_valid;

  // A start mark hides every stored entry, so the entry that carries it
  // sees a cleared table.
  always_comb begin
    idx      = req_i.idx[IdxW-1:0];
    rd_valid = req_i.hit && !req_i.start && valid_q[idx];
    count_o  = rd_valid ? cnt_q[idx] : '0;
    sum_o    = rd_valid ? sum_q[idx] : '0;

    valid_d = valid_q;
    if (step_i) begin
      if (req_i.start) begin
        valid_d = '0;
      end
      if (req_i.hit) begin
        valid_d[idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && req_i.hit) begin
      cnt_q[idx] <= count_o + alis_pkg::CountW'(1);
      sum_q[idx] <= sum_o + alis_pkg::SumW'(length_i);
    end
  end

endmodule

FILE: sv/avi_legacy_index_splitter.sv
// Channel   Direction  Signals                                 Payload
// in        sink       in_valid_i / in_ready_o                 in_data_i (in_item_t)
// out       source     out_valid_o / out_ready_i               out_data_o (out_item_t)
// cfg       sink       cfg_valid_i / cfg_ready_o               cfg_index_i, cfg_data_i
//
// One entry is taken in every cycle while the output is not stalled; a result
// passes through the input register and then the result register before it is
// presented on the output.
// The per-stream count and sum are read and updated in the same cycle from
// flip-flop arrays, so consecutive entries of one stream need no stall.
// Reset clears the mode bit, the configuration and every entry's valid bit at once.
// A stalled output holds its result while one further entry waits in the input register.
module avi_legacy_index_splitter #(
  parameter int unsigned MAX_STREAMS = alis_pkg::MaxStreams
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  alis_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output alis_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [alis_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [alis_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [alis_pkg::WordW-1:0]       movie_pos_q;
  logic [alis_pkg::StreamCntW-1:0]  stream_count_q;
  logic                             abs_mode_q;
  logic                             abs_mode_d;

  logic                             in_valid_q;
  logic                             in_valid_d;
  alis_pkg::in_item_t               in_item_q;
  logic                             out_valid_q;
  logic                             out_valid_d;
  alis_pkg::out_item_t              out_item_q;
  alis_pkg::out_item_t              out_item_d;

  logic                             advance;
  alis_pkg::tbl_req_t               tbl_req;
  logic [alis_pkg::OffsetW-1:0]     file_offset;
  logic [alis_pkg::CountW-1:0]      tbl_count;
  logic [alis_pkg::SumW-1:0]        tbl_sum;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      movie_pos_q    <= '0;
      stream_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (alis_pkg::cfg_reg_e'(cfg_index_i))
        alis_pkg::CfgMoviePos: begin
          movie_pos_q <= cfg_data_i[alis_pkg::WordW-1:0];
        end
        alis_pkg::CfgStreamCount: begin
          stream_count_q <= cfg_data_i[alis_pkg::StreamCntW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  alis_entry_decode #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_decode (
    .item_i         (in_item_q),
    .movie_pos_i    (movie_pos_q),
    .stream_count_i (stream_count_q),
    .abs_mode_q_i   (abs_mode_q),
    .req_o          (tbl_req),
    .abs_mode_o     (abs_mode_d),
    .file_offset_o  (file_offset)
  );

  alis_stream_table #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tbl_req),
    .step_i   (advance),
    .length_i (in_item_q.entry_length),
    .count_o  (tbl_count),
    .sum_o    (tbl_sum)
  );

  always_comb begin
    in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && !out_ready_i);

    out_item_d = '0;
    if (tbl_req.hit) begin
      out_item_d.accepted           = 1'b1;
      out_item_d.stream_number      = tbl_req.idx[3:0];
      out_item_d.position_in_stream = tbl_count;
      out_item_d.file_offset        = file_offset;
      out_item_d.chunk_length       = in_item_q.entry_length;
      out_item_d.chunk_flags        = in_item_q.entry_flags;
      out_item_d.length_before      = tbl_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      abs_mode_q  <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        abs_mode_q <= abs_mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  a_dropped_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |->
      out_data_o.position_in_stream == '0 && out_data_o.file_offset == '0 &&
      out_data_o.length_before == '0 && out_data_o.chunk_length == '0)
    else $error("Dropped entry carries non-zero fields.");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_item_q.start_of_table && tbl_req.hit |=>
      out_data_o.position_in_stream == '0 && out_data_o.length_before == '0)
    else $error("Entry with a start mark did not see a cleared table.");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_valid_q |=> !out_valid_o)
    else $error("Result appeared with no entry in the input register.");

endmodule
